### src/varint32_group_decoder_macros.svh
// assertion macros shared by the varint32 group decoder modules
// depends on nothing; included by the files that check their own logic
`ifndef VARINT32_GROUP_DECODER_MACROS_SVH
`define VARINT32_GROUP_DECODER_MACROS_SVH

// same-cycle implication, disabled during reset
`define VGD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define VGD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/vgd_pkg.sv
// shared constants and types of the varint32 group decoder
// depends on nothing; imported by every module of the block
package vgd_pkg;

    localparam int GROUP_BYTES = 8;
    localparam int IDX_W       = (GROUP_BYTES > 1) ? $clog2(GROUP_BYTES) : 1;
    localparam int CNT_W       = 4;
    localparam int VALUE_W     = 32;
    localparam int PAY_W       = 7;
    localparam int TOP_W       = 4;

    // byte position codes within one varint
    localparam logic [2:0] POS_TOP   = 3'd4;
    localparam logic [2:0] MAX_BYTES = 3'd5;

    // decoded values of one group, one slot per byte that ends a varint
    typedef struct packed {
        logic [GROUP_BYTES-1:0][VALUE_W-1:0] value;
        logic [GROUP_BYTES-1:0]              overlong;
        logic [GROUP_BYTES-1:0]              hit;
    } dec_res_t;

endpackage

### src/vgd_decode.sv
// single-pass decode of one byte group into per-byte varint results
// depends on vgd_pkg; holds the varint carry state between groups
`include "varint32_group_decoder_macros.svh"

module vgd_decode (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic [8*vgd_pkg::GROUP_BYTES-1:0] byte_group,
    input  logic [vgd_pkg::CNT_W-1:0]      valid_count,
    input  logic                          end_of_stream,
    output vgd_pkg::dec_res_t              res
);
    import vgd_pkg::*;

    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [2:0]         pos_reg, pos_next;
    logic               ov_reg, ov_next;
    logic [CNT_W-1:0]   cnt;

    // clamp the byte count to the group size
    assign cnt = (valid_count > CNT_W'(GROUP_BYTES)) ? CNT_W'(GROUP_BYTES) : valid_count;

    // walk the bytes of the group in stream order
    always_comb
    begin
        logic [7:0]         b;
        logic [VALUE_W-1:0] contrib;
        logic [VALUE_W-1:0] acc;
        logic [2:0]         pos;
        logic               ov;
        acc = acc_reg;
        pos = pos_reg;
        ov  = ov_reg;
        res = '0;
        for (int i = 0; i < GROUP_BYTES; i++)
        begin
            b       = byte_group[8*i +: 8];
            contrib = '0;
            if (i < int'(cnt))
            begin
                case (pos)
                    3'd0:    contrib = {{(VALUE_W-PAY_W){1'b0}}, b[PAY_W-1:0]};
                    3'd1:    contrib = {{(VALUE_W-2*PAY_W){1'b0}}, b[PAY_W-1:0],
                                        {PAY_W{1'b0}}};
                    3'd2:    contrib = {{(VALUE_W-3*PAY_W){1'b0}}, b[PAY_W-1:0],
                                        {(2*PAY_W){1'b0}}};
                    3'd3:    contrib = {{(VALUE_W-4*PAY_W){1'b0}}, b[PAY_W-1:0],
                                        {(3*PAY_W){1'b0}}};
                    POS_TOP: contrib = {b[TOP_W-1:0], {(VALUE_W-TOP_W){1'b0}}};
                    default: ov = 1'b1;
                endcase
                acc = acc | contrib;
                if (b[7])
                begin
                    if (pos < MAX_BYTES)
                    begin
                        pos = pos + 3'd1;
                    end
                end
                else
                begin
                    res.value[i]    = acc;
                    res.overlong[i] = ov;
                    res.hit[i]      = 1'b1;
                    acc = '0;
                    pos = '0;
                    ov  = 1'b0;
                end
            end
        end
        acc_next = end_of_stream ? '0   : acc;
        pos_next = end_of_stream ? 3'd0 : pos;
        ov_next  = end_of_stream ? 1'b0 : ov;
    end

    // carry state across groups
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            pos_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else if (en)
        begin
            acc_reg <= acc_next;
            pos_reg <= pos_next;
            ov_reg  <= ov_next;
        end
    end

    `VGD_ASSERT_NOW(a_pos_range, clk, rst_n, 1'b1, pos_reg <= MAX_BYTES,
        "byte position beyond five")
    `VGD_ASSERT_NEXT(a_eos_clears, clk, rst_n, en && end_of_stream,
        pos_reg == 3'd0 && acc_reg == '0 && !ov_reg, "end of stream left state behind")

endmodule

### src/vgd_out_buf.sv
// result buffer that holds one group's decoded values and hands them out in order
// depends on vgd_pkg; fed by vgd_decode through the top level
`include "varint32_group_decoder_macros.svh"

module vgd_out_buf (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  vgd_pkg::dec_res_t           res,
    output logic                        can_load,
    output logic                        tvalid,
    input  logic                        tready,
    output logic [vgd_pkg::VALUE_W-1:0] value,
    output logic                        overlong,
    output logic                        last
);
    import vgd_pkg::*;

    logic [GROUP_BYTES-1:0]              pend_reg, pend_next;
    logic [GROUP_BYTES-1:0][VALUE_W-1:0] value_reg;
    logic [GROUP_BYTES-1:0]              ov_reg;
    logic [GROUP_BYTES-1:0]              low_bit;
    logic [GROUP_BYTES-1:0]              rest;
    logic [IDX_W-1:0]                    idx;
    logic                                take;

    // lowest pending slot goes out first
    always_comb
    begin
        idx = '0;
        for (int i = GROUP_BYTES - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                idx = IDX_W'(i);
            end
        end
    end

    assign low_bit  = pend_reg & (~pend_reg + GROUP_BYTES'(1));
    assign rest     = pend_reg & ~low_bit;
    assign tvalid   = |pend_reg;
    assign take     = tvalid && tready;
    assign last     = (rest == '0);
    assign value    = value_reg[idx];
    assign overlong = ov_reg[idx];
    assign can_load = (pend_reg == '0) || (take && last);

    // pending mask update
    always_comb
    begin
        if (load)
        begin
            pend_next = res.hit;
        end
        else if (take)
        begin
            pend_next = rest;
        end
        else
        begin
            pend_next = pend_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= res.value;
            ov_reg    <= res.overlong;
        end
    end

    `VGD_ASSERT_NOW(a_load_when_free, clk, rst_n, load,
        pend_reg == '0 || (take && last), "group loaded over pending results")
    `VGD_ASSERT_NOW(a_last_single, clk, rst_n, tvalid && last,
        $onehot(pend_reg), "last flagged with several results pending")
    `VGD_ASSERT_NEXT(a_drain_one, clk, rst_n, take && !load,
        $countones(pend_reg) + 1 == $past($countones(pend_reg)),
        "drain did not retire exactly one result")

endmodule

### src/varint32_group_decoder.sv
// path: a group accepted into the input stage is decoded combinationally and written into
//   the result buffer once that buffer can load; its first value is valid in the cycle after
// throughput: one group per cycle while groups end at most one varint and the receiver is
//   ready; a group that ends several varints holds the result buffer until all have left
// reset: rst_n asynchronous active low clears the input stage, the carry state
//   and the result buffer; no clearing pass
// top level; depends on vgd_pkg, vgd_decode and vgd_out_buf
module varint32_group_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // byte_group[63:0], valid_count[67:64], zero pad
    input  logic        s_axis_tlast,   // end_of_stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // value[31:0], overlong[32], zero pad
    output logic        m_axis_tlast    // last value of its group
);
    import vgd_pkg::*;

    logic                       in_valid_reg;
    logic [8*GROUP_BYTES-1:0]   group_reg;
    logic [CNT_W-1:0]           count_reg;
    logic                       eos_reg;
    logic                       can_load;
    logic                       load;
    logic                       in_take;
    dec_res_t                   res;
    logic [VALUE_W-1:0]         out_value;
    logic                       out_overlong;

    assign load          = in_valid_reg && can_load;
    assign s_axis_tready = !in_valid_reg || can_load;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            group_reg <= s_axis_tdata[8*GROUP_BYTES-1:0];
            count_reg <= s_axis_tdata[64 +: CNT_W];
            eos_reg   <= s_axis_tlast;
        end
    end

    vgd_decode u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (load),
        .byte_group    (group_reg),
        .valid_count   (count_reg),
        .end_of_stream (eos_reg),
        .res           (res)
    );

    vgd_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .res      (res),
        .can_load (can_load),
        .tvalid   (m_axis_tvalid),
        .tready   (m_axis_tready),
        .value    (out_value),
        .overlong (out_overlong),
        .last     (m_axis_tlast)
    );

    // pack the result
    assign m_axis_tdata = {7'b0, out_overlong, out_value};

endmodule

### test/varint32_group_decoder_tb.sv
// self-checking testbench for the varint32 group decoder: directed and random byte groups
// depends on vgd_pkg and the varint32_group_decoder top level; holds its own decode predictor
module varint32_group_decoder_tb;
    import vgd_pkg::*;

    localparam int RANDOM_GROUPS = 360;
    localparam int MAX_COUNT     = (1 << CNT_W) - 1;

    // one request on the input stream, with the idle cycles that precede it
    typedef struct {
        logic [8*GROUP_BYTES-1:0] data;
        logic [CNT_W-1:0]         count;
        logic                     eos;
        int                       gap;
    } group_req_t;

    // one decoded value as it should leave the block
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               overlong;
        logic               last;
    } varint_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;     // byte_group[63:0], valid_count[67:64], zero pad
    logic        s_axis_tlast = 1'b0;   // end_of_stream
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // value[31:0], overlong[32], zero pad
    logic        m_axis_tlast;          // last value of its group

    group_req_t     pending_groups[$];
    varint_result_t expected_values[$];
    group_req_t     offered;
    logic [7:0]     varint_bytes[$];

    // carry state of the predictor
    logic [VALUE_W-1:0] carry_value = '0;
    logic [2:0]         carry_pos = '0;
    logic               carry_overlong = 1'b0;

    int   items_total = 0;
    int   items_accepted = 0;
    int   results_predicted = 0;
    int   results_checked = 0;
    int   fault_count = 0;
    int   quiet_left = 0;
    int   idle_cycles = 0;
    int   stall_left = 0;
    int   steady_left = 0;
    int   stall_draw;
    logic launch;
    logic ready_next;
    logic hold_active = 1'b0;

    varint32_group_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // queue one request, with runs of back-to-back requests now and then
    task automatic add_group(input logic [8*GROUP_BYTES-1:0] data, input int count,
                             input logic eos);
        group_req_t req;
        req.data  = data;
        req.count = count[CNT_W-1:0];
        req.eos   = eos;
        if (quiet_left == 0 && $urandom_range(0, 5) == 0)
            quiet_left = $urandom_range(10, 30);
        if (quiet_left > 0)
        begin
            quiet_left--;
            req.gap = 0;
        end
        else
        begin
            req.gap = $urandom_range(0, 19);
        end
        pending_groups.push_back(req);
        items_total++;
    endtask

    // decode one accepted request and queue the values it ends
    task automatic decode_group(input group_req_t req);
        varint_result_t     found[GROUP_BYTES];
        int                 n_found;
        int                 n_bytes;
        logic [7:0]         b;
        logic [VALUE_W-1:0] pay_word;
        n_found = 0;
        n_bytes = (req.count > GROUP_BYTES) ? GROUP_BYTES : req.count;
        for (int i = 0; i < n_bytes; i++)
        begin
            b = req.data[8*i +: 8];
            // payload placement, the fifth byte keeps only its low bits
            if (carry_pos < POS_TOP)
            begin
                pay_word = VALUE_W'(b[PAY_W-1:0]);
                carry_value |= pay_word << (PAY_W * carry_pos);
            end
            else if (carry_pos == POS_TOP)
            begin
                pay_word = VALUE_W'(b[TOP_W-1:0]);
                carry_value |= pay_word << (PAY_W * POS_TOP);
            end
            else
            begin
                carry_overlong = 1'b1;
            end
            // continuation or end of the varint
            if (b[7])
            begin
                if (carry_pos < MAX_BYTES)
                    carry_pos = carry_pos + 3'd1;
            end
            else
            begin
                found[n_found].value    = carry_value;
                found[n_found].overlong = carry_overlong;
                found[n_found].last     = 1'b0;
                n_found++;
                carry_value    = '0;
                carry_pos      = '0;
                carry_overlong = 1'b0;
            end
        end
        for (int j = 0; j < n_found; j++)
        begin
            found[j].last = (j == n_found - 1);
            expected_values.push_back(found[j]);
        end
        results_predicted += n_found;
        // end of stream drops any unfinished varint
        if (req.eos)
        begin
            carry_value    = '0;
            carry_pos      = '0;
            carry_overlong = 1'b0;
        end
    endtask

    // request driver, fed from pending_groups
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            idle_cycles   <= 0;
        end
        else
        begin
            launch = 1'b0;
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_group(offered);
                items_accepted++;
                launch = (pending_groups.size() != 0) &&
                         (pending_groups[0].gap == 0 || hold_active);
            end
            else if (!s_axis_tvalid && pending_groups.size() != 0)
            begin
                if (idle_cycles >= pending_groups[0].gap || hold_active)
                    launch = 1'b1;
                else
                    idle_cycles <= idle_cycles + 1;
            end
            if (launch)
            begin
                offered = pending_groups.pop_front();
                s_axis_tdata  <= {4'b0, offered.count, offered.data};
                s_axis_tlast  <= offered.eos;
                s_axis_tvalid <= 1'b1;
                idle_cycles   <= 0;
            end
            else if (s_axis_tvalid && s_axis_tready)
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            ready_next = m_axis_tready;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_values.size() == 0)
                begin
                    if (fault_count < 10)
                        $display("unexpected value %h overlong %b last %b",
                                 m_axis_tdata[31:0], m_axis_tdata[32], m_axis_tlast);
                    fault_count++;
                end
                else
                begin
                    if (expected_values[0].value    !== m_axis_tdata[31:0] ||
                        expected_values[0].overlong !== m_axis_tdata[32] ||
                        expected_values[0].last     !== m_axis_tlast)
                    begin
                        if (fault_count < 10)
                            $display("mismatch: expected %h/%b/%b, got %h/%b/%b",
                                     expected_values[0].value, expected_values[0].overlong,
                                     expected_values[0].last, m_axis_tdata[31:0],
                                     m_axis_tdata[32], m_axis_tlast);
                        fault_count++;
                    end
                    void'(expected_values.pop_front());
                    results_checked++;
                end
                // stall before the next result, with stall-free runs now and then
                if (steady_left > 0)
                begin
                    steady_left--;
                    stall_draw = 0;
                end
                else if ($urandom_range(0, 11) == 0)
                begin
                    steady_left = $urandom_range(10, 40);
                    stall_draw  = 0;
                end
                else
                begin
                    stall_draw = $urandom_range(0, 19);
                end
                stall_left = stall_draw;
                ready_next = (stall_draw == 0);
            end
            else if (!m_axis_tready)
            begin
                if (stall_left > 0)
                    stall_left--;
                ready_next = (stall_left == 0);
            end
            if (hold_active)
                ready_next = 1'b0;
            m_axis_tready <= ready_next;
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial
    begin
        wait (items_accepted >= 60);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (400) @(posedge clk);
        hold_active <= 1'b0;
    end

    // watchdog
    initial
    begin
        #5000000;
        $display("varint32_group_decoder_tb: done, errors");
        $finish;
    end

    // stimulus and end of run
    initial
    begin
        logic [8*GROUP_BYTES-1:0] data;
        int                       take;
        int                       len;
        int                       cnt;
        int                       busy_groups;
        logic                     eos;

        // directed: single bytes, extremes, eight values in one group
        add_group(64'h0, 1, 1'b0);
        add_group(64'hFFFF_FFFF_FFFF_FF7F, 1, 1'b0);
        add_group(64'h0102_0304_0506_7F00, 8, 1'b0);
        // five-byte maximum, and a fifth byte with its dropped bits set
        add_group(64'h0000_000F_FFFF_FFFF, 5, 1'b0);
        add_group(64'h0000_007F_FFFF_FFFF, 5, 1'b0);
        add_group(64'h0000_0070_8080_8080, 5, 1'b0);
        // overlong within a group and across groups
        add_group(64'h0001_FFFF_FFFF_FFFF, 7, 1'b0);
        add_group(64'hFFFF_FFFF_FFFF_FFFF, 8, 1'b0);
        add_group(64'hFFFF_FFFF_FFFF_FF80, 8, 1'b0);
        add_group(64'hAAAA_AAAA_AAAA_AA00, 1, 1'b0);
        // value spanning three groups
        add_group(64'h80, 1, 1'b0);
        add_group(64'h80, 1, 1'b0);
        add_group(64'h01, 1, 1'b0);
        // count above the group size
        add_group(64'h0505_0505_0505_0505, MAX_COUNT, 1'b0);
        add_group(64'h0102_0304_0506_0708, GROUP_BYTES + 1, 1'b0);
        // junk past the count, empty groups
        add_group(64'hFFFF_FFFF_FF03_8281, 3, 1'b0);
        add_group(64'h1234_5678_9ABC_DEF0, 0, 1'b0);
        add_group(64'hFF, 1, 1'b0);
        add_group(64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b1);
        add_group(64'h7E, 1, 1'b0);
        // end of stream with a partial varint, with and without values before it
        add_group(64'h8281, 2, 1'b1);
        add_group(64'h05, 1, 1'b0);
        add_group(64'h8403, 2, 1'b1);
        add_group(64'hFFFF_FFFF_FFFF_FFFF, 8, 1'b1);
        add_group(64'h0000_0000_0000_0400, 4, 1'b1);

        // random: well-formed varint streams cut into groups, plus noise
        busy_groups = 0;
        while (busy_groups < RANDOM_GROUPS)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                cnt = $urandom_range(0, MAX_COUNT);
                add_group({$urandom, $urandom}, cnt, $urandom_range(0, 9) == 0);
                if (cnt != 0)
                    busy_groups++;
            end
            else
            begin
                while (varint_bytes.size() < GROUP_BYTES)
                begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 10)
                                                      : $urandom_range(1, 5);
                    for (int k = 0; k < len; k++)
                        varint_bytes.push_back({k != len - 1, 7'($urandom)});
                end
                take = $urandom_range(1, GROUP_BYTES);
                data = {$urandom, $urandom};
                for (int k = 0; k < take; k++)
                    data[8*k +: 8] = varint_bytes.pop_front();
                cnt = take;
                if (take == GROUP_BYTES && $urandom_range(0, 4) == 0)
                    cnt = $urandom_range(GROUP_BYTES + 1, MAX_COUNT);
                eos = ($urandom_range(0, 29) == 0);
                if (eos)
                    varint_bytes.delete();
                add_group(data, cnt, eos);
                busy_groups++;
            end
        end

        // reset
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // drain
        wait (items_accepted == items_total);
        wait (results_checked == results_predicted);
        repeat (10) @(posedge clk);
        if (results_checked != results_predicted)
            fault_count++;
        if (fault_count == 0)
            $display("varint32_group_decoder_tb: done, clean");
        else
            $display("varint32_group_decoder_tb: done, errors");
        $finish;
    end

endmodule
